// ===== rtl/shb_pkg.sv =====
// Shared constants, types and helper functions of the spherical harmonic basis block.
package shb_pkg;

    localparam int DW        = 16;
    localparam int BC_W      = 3;
    localparam int IDX_W     = 4;
    localparam int NCOEF     = 16;
    localparam int UQ_W      = DW + 1;
    localparam int DIV_STEPS = DW;
    localparam int REM_W     = 2 * DW;
    localparam int POLY_W    = 36;
    localparam int PROD_W    = POLY_W + UQ_W;
    localparam int K_W       = 23;
    localparam int ACC_W     = POLY_W + K_W;
    localparam int OUT_SH    = 51 - DW;

    localparam logic signed [UQ_W-1:0] UNIT_ONE = UQ_W'(1) <<< (DW - 1);
    localparam logic [BC_W-1:0] BANDS_RESET = 3'd4;
    localparam logic [0:0] REG_BAND_COUNT = 1'b0;

    typedef logic signed [POLY_W-1:0] poly_t;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic signed [UQ_W-1:0] u;
        logic signed [UQ_W-1:0] v;
        logic signed [UQ_W-1:0] w;
    } unit_vec_t;

    typedef struct packed {
        logic                    valid;
        logic                    degen;
        poly_t [NCOEF-1:0]       poly;
    } poly_set_t;

    // Normalization constants in Q20, one per coefficient index.
    function automatic logic signed [K_W-1:0] coef_k(input logic [IDX_W-1:0] idx);
        logic signed [K_W-1:0] k;
        begin
            case (idx)
                4'd0:    k = 23'sd295798;
                4'd1:    k = 23'sd512337;
                4'd2:    k = 23'sd512337;
                4'd3:    k = 23'sd512337;
                4'd4:    k = 23'sd1145620;
                4'd5:    k = 23'sd1145620;
                4'd6:    k = 23'sd330712;
                4'd7:    k = 23'sd1145620;
                4'd8:    k = 23'sd572810;
                4'd9:    k = 23'sd618706;
                4'd10:   k = 23'sd3031026;
                4'd11:   k = 23'sd479247;
                4'd12:   k = 23'sd391304;
                4'd13:   k = 23'sd479247;
                4'd14:   k = 23'sd1515513;
                default: k = 23'sd618706;
            endcase
            return k;
        end
    endfunction

    // Index of the final coefficient; band counts outside 2..4 are clamped.
    function automatic logic [IDX_W-1:0] last_index(input logic [BC_W-1:0] bc);
        logic [IDX_W-1:0] li;
        begin
            case (bc)
                3'd0, 3'd1, 3'd2: li = 4'd3;
                3'd3:             li = 4'd8;
                default:          li = 4'd15;
            endcase
            return li;
        end
    endfunction

    // Drop 15 fraction bits, rounding half away from zero.
    function automatic poly_t round15(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] s;
        begin
            mag = x[PROD_W-1] ? (~x + 1'b1) : x;
            r   = (mag + (PROD_W'(1) << 14)) >> 15;
            s   = x[PROD_W-1] ? (~r + 1'b1) : r;
            return poly_t'(s[POLY_W-1:0]);
        end
    endfunction

endpackage

// ===== rtl/spherical_harmonic_basis.sv =====
// Throughput: one coefficient per cycle; band_count sets 4, 9 or 16 coefficients per
// direction. The coefficient sequencer is the limit: while it is occupied and a
// finished item waits, the whole pipeline stalls.
// busy rises when the sequencer is occupied and the pipeline tail holds a finished item.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets band_count to 4.
// Results cannot be stalled by the receiver.
module spherical_harmonic_basis
    import shb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [DW-1:0] dir_x,
    input  logic signed [DW-1:0] dir_y,
    input  logic signed [DW-1:0] dir_z,
    input  logic [DW-1:0]        radius,
    output logic                 coef_valid,
    output logic [IDX_W-1:0]     coef_index,
    output logic signed [DW-1:0] coef_value,
    output logic                 degenerate,
    output logic                 last
);

    logic [BC_W-1:0] band_count_reg;
    logic            reg_hit;
    logic            adv;
    logic            emit_ready;
    unit_vec_t       uv;
    poly_set_t       ps;

    // Configuration register transfer.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == REG_BAND_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_count_reg <= BANDS_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            band_count_reg <= pwdata[BC_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(32 - BC_W){1'b0}}, band_count_reg} : '0;

    // The pipeline moves unless a finished item waits on a busy sequencer.
    assign adv  = emit_ready || !ps.valid;
    assign busy = !adv;

    shb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (start),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .radius   (radius),
        .uv_out   (uv)
    );

    shb_poly u_poly (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .uv_in  (uv),
        .ps_out (ps)
    );

    shb_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ps_in      (ps),
        .band_count (band_count_reg),
        .ready      (emit_ready),
        .coef_valid (coef_valid),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .degenerate (degenerate),
        .last       (last)
    );

endmodule

// ===== rtl/shb_div.sv =====
// Pipelined restoring divider forming the clamped Q15 unit direction.
module shb_div
    import shb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] dir_x,
    input  logic signed [DW-1:0] dir_y,
    input  logic signed [DW-1:0] dir_z,
    input  logic [DW-1:0]        radius,
    output unit_vec_t            uv_out
);

    logic                   val_reg [0:DIV_STEPS];
    logic                   deg_reg [0:DIV_STEPS];
    logic [DW-1:0]          rad_reg [0:DIV_STEPS];
    logic [2:0][REM_W-1:0]  rem_reg [0:DIV_STEPS];
    logic [2:0][DW-1:0]     quo_reg [0:DIV_STEPS];
    logic [2:0]             neg_reg [0:DIV_STEPS];
    logic [2:0]             ovf_reg [0:DIV_STEPS];

    logic [2:0][REM_W-1:0]  num_next;
    logic [2:0]             neg_next;
    logic [2:0]             ovf_next;
    logic signed [DW-1:0]   comp [0:2];
    logic                   out_valid_reg;
    unit_vec_t              out_reg;
    unit_vec_t              out_next;

    assign comp[0] = dir_x;
    assign comp[1] = dir_y;
    assign comp[2] = dir_z;

    // Entry: magnitude, rounding bias and the early overflow check.
    always_comb
    begin
        logic signed [DW:0] ext;
        logic [DW:0]        mag;
        for (int c = 0; c < 3; c++)
        begin
            ext         = {comp[c][DW-1], comp[c]};
            mag         = ext[DW] ? (DW+1)'(0) - ext : ext;
            num_next[c] = {mag, {(DW-1){1'b0}}} + REM_W'(radius >> 1);
            neg_next[c] = comp[c][DW-1];
            ovf_next[c] = num_next[c] >= {radius, {DW{1'b0}}};
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                val_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            val_reg[0] <= in_valid;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                val_reg[j+1] <= val_reg[j];
            end
            out_valid_reg <= val_reg[DIV_STEPS];
        end
    end

    // First stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg[0] <= (radius == '0);
            rad_reg[0] <= radius;
            rem_reg[0] <= num_next;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg_next;
            ovf_reg[0] <= ovf_next;
        end
    end

    // One quotient bit per stage for each component.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        localparam int SH = DIV_STEPS - 1 - j;
        logic [REM_W-1:0] trial;
        assign trial = REM_W'(rad_reg[j]) << SH;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                deg_reg[j+1] <= deg_reg[j];
                rad_reg[j+1] <= rad_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                for (int c = 0; c < 3; c++)
                begin
                    if (rem_reg[j][c] >= trial)
                    begin
                        rem_reg[j+1][c] <= rem_reg[j][c] - trial;
                        quo_reg[j+1][c] <= {quo_reg[j][c][DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j+1][c] <= rem_reg[j][c];
                        quo_reg[j+1][c] <= {quo_reg[j][c][DW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Clamp to one and restore the sign.
    always_comb
    begin
        logic signed [UQ_W-1:0] q [0:2];
        for (int c = 0; c < 3; c++)
        begin
            if (ovf_reg[DIV_STEPS][c] || ({1'b0, quo_reg[DIV_STEPS][c]} > UNIT_ONE))
            begin
                q[c] = UNIT_ONE;
            end
            else
            begin
                q[c] = {1'b0, quo_reg[DIV_STEPS][c]};
            end
            if (neg_reg[DIV_STEPS][c])
            begin
                q[c] = -q[c];
            end
        end
        out_next.valid = val_reg[DIV_STEPS];
        out_next.degen = deg_reg[DIV_STEPS];
        out_next.u     = q[0];
        out_next.v     = q[1];
        out_next.w     = q[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    // The reset valid bit replaces the payload copy.
    always_comb
    begin
        uv_out       = out_reg;
        uv_out.valid = out_valid_reg;
    end

endmodule

// ===== rtl/shb_poly.sv =====
// Four-stage pipeline evaluating the sixteen basis polynomials in Q30.
module shb_poly
    import shb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  unit_vec_t uv_in,
    output poly_set_t ps_out
);

    logic [3:0] val_reg;
    logic [3:0] deg_reg;

    // Stage one: squares and pair products.
    logic signed [UQ_W-1:0] u1_reg, v1_reg, w1_reg;
    poly_t uu1_reg, vv1_reg, ww1_reg, uv1_reg, vw1_reg, wu1_reg;

    // Stage two: sums feeding the cubic terms.
    logic signed [UQ_W-1:0] u2_reg, v2_reg, w2_reg;
    poly_t uv2_reg, vw2_reg, wu2_reg, p6_2_reg, s14_2_reg;
    poly_t s9_2_reg, t4_2_reg, s12_2_reg, s15_2_reg;

    // Stage three: cubic products.
    logic signed [UQ_W-1:0] u3_reg, v3_reg, w3_reg;
    poly_t uv3_reg, vw3_reg, wu3_reg, p6_3_reg, p8_3_reg;
    logic signed [PROD_W-1:0] m9_reg, m10_reg, m11_reg, m12_reg, m13_reg, m14_reg, m15_reg;

    poly_t [NCOEF-1:0] poly_reg;

    // Valid and degenerate flags travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (adv)
        begin
            val_reg <= {val_reg[2:0], uv_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg <= {deg_reg[2:0], uv_in.degen};

            u1_reg  <= uv_in.u;
            v1_reg  <= uv_in.v;
            w1_reg  <= uv_in.w;
            uu1_reg <= uv_in.u * uv_in.u;
            vv1_reg <= uv_in.v * uv_in.v;
            ww1_reg <= uv_in.w * uv_in.w;
            uv1_reg <= uv_in.u * uv_in.v;
            vw1_reg <= uv_in.v * uv_in.w;
            wu1_reg <= uv_in.w * uv_in.u;

            u2_reg    <= u1_reg;
            v2_reg    <= v1_reg;
            w2_reg    <= w1_reg;
            uv2_reg   <= uv1_reg;
            vw2_reg   <= vw1_reg;
            wu2_reg   <= wu1_reg;
            p6_2_reg  <= (ww1_reg <<< 1) - uu1_reg - vv1_reg;
            s14_2_reg <= uu1_reg - vv1_reg;
            s9_2_reg  <= (uu1_reg <<< 1) + uu1_reg - vv1_reg;
            t4_2_reg  <= (ww1_reg <<< 2) - uu1_reg - vv1_reg;
            s12_2_reg <= (ww1_reg <<< 1) - (uu1_reg <<< 1) - uu1_reg
                         - (vv1_reg <<< 1) - vv1_reg;
            s15_2_reg <= uu1_reg - (vv1_reg <<< 1) - vv1_reg;

            u3_reg   <= u2_reg;
            v3_reg   <= v2_reg;
            w3_reg   <= w2_reg;
            uv3_reg  <= uv2_reg;
            vw3_reg  <= vw2_reg;
            wu3_reg  <= wu2_reg;
            p6_3_reg <= p6_2_reg;
            p8_3_reg <= s14_2_reg;
            m9_reg   <= s9_2_reg * v2_reg;
            m10_reg  <= uv2_reg * w2_reg;
            m11_reg  <= t4_2_reg * v2_reg;
            m12_reg  <= s12_2_reg * w2_reg;
            m13_reg  <= t4_2_reg * u2_reg;
            m14_reg  <= s14_2_reg * w2_reg;
            m15_reg  <= s15_2_reg * u2_reg;
        end
    end

    // Stage four: round the cubic terms and gather all polynomials.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            poly_reg[0]  <= poly_t'(1) <<< 30;
            poly_reg[1]  <= poly_t'(v3_reg) <<< 15;
            poly_reg[2]  <= poly_t'(w3_reg) <<< 15;
            poly_reg[3]  <= poly_t'(u3_reg) <<< 15;
            poly_reg[4]  <= uv3_reg;
            poly_reg[5]  <= vw3_reg;
            poly_reg[6]  <= p6_3_reg;
            poly_reg[7]  <= wu3_reg;
            poly_reg[8]  <= p8_3_reg;
            poly_reg[9]  <= round15(m9_reg);
            poly_reg[10] <= round15(m10_reg);
            poly_reg[11] <= round15(m11_reg);
            poly_reg[12] <= round15(m12_reg);
            poly_reg[13] <= round15(m13_reg);
            poly_reg[14] <= round15(m14_reg);
            poly_reg[15] <= round15(m15_reg);
        end
    end

    always_comb
    begin
        ps_out.poly  = poly_reg;
        ps_out.valid = val_reg[3];
        ps_out.degen = deg_reg[3];
    end

endmodule

// ===== rtl/shb_emit.sv =====
// Coefficient sequencer: scales one polynomial per cycle and drives the result ports.
module shb_emit
    import shb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  poly_set_t            ps_in,
    input  logic [BC_W-1:0]      band_count,
    output logic                 ready,
    output logic                 coef_valid,
    output logic [IDX_W-1:0]     coef_index,
    output logic signed [DW-1:0] coef_value,
    output logic                 degenerate,
    output logic                 last
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (DW - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [IDX_W-1:0]        last_k;
    logic                    load;
    logic                    active_reg;
    logic [IDX_W-1:0]        k_reg;
    poly_t [NCOEF-1:0]       cur_poly_reg;
    logic                    cur_deg_reg;

    logic                    a_valid_reg;
    logic signed [ACC_W-1:0] a_prod_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic                    a_last_reg;
    logic                    a_deg_reg;

    logic signed [ACC_W-1:0] rnd_val;

    logic                    coef_valid_reg;
    logic [IDX_W-1:0]        coef_index_reg;
    logic signed [DW-1:0]    coef_value_reg;
    logic                    degenerate_reg;
    logic                    last_reg;

    assign last_k = last_index(band_count);
    assign ready  = !active_reg || (k_reg == last_k);
    assign load   = ps_in.valid && ready;

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            k_reg       <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (active_reg)
            begin
                if (k_reg == last_k)
                begin
                    active_reg <= 1'b0;
                end
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Hold the current item and scale the selected polynomial.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_poly_reg <= ps_in.poly;
            cur_deg_reg  <= ps_in.degen;
        end
        a_prod_reg <= coef_k(k_reg) * cur_poly_reg[k_reg];
        a_idx_reg  <= k_reg;
        a_last_reg <= (k_reg == last_k);
        a_deg_reg  <= cur_deg_reg;
    end

    // Round half away from zero to the output format.
    always_comb
    begin
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = a_prod_reg[ACC_W-1] ? (~a_prod_reg + 1'b1) : a_prod_reg;
        r   = (mag + (ACC_W'(1) << (OUT_SH - 1))) >> OUT_SH;
        rnd_val = a_prod_reg[ACC_W-1] ? -$signed(r) : $signed(r);
    end

    // Result register with saturation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= 1'b0;
        end
        else
        begin
            coef_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_index_reg <= a_idx_reg;
        last_reg       <= a_last_reg;
        degenerate_reg <= a_deg_reg;
        if (a_deg_reg)
        begin
            coef_value_reg <= '0;
        end
        else if (rnd_val > SAT_HI)
        begin
            coef_value_reg <= SAT_HI[DW-1:0];
        end
        else if (rnd_val < SAT_LO)
        begin
            coef_value_reg <= SAT_LO[DW-1:0];
        end
        else
        begin
            coef_value_reg <= rnd_val[DW-1:0];
        end
    end

    assign coef_valid = coef_valid_reg;
    assign coef_index = coef_index_reg;
    assign coef_value = coef_value_reg;
    assign degenerate = degenerate_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid_reg && !last_reg |=> coef_valid_reg
            && coef_index_reg == IDX_W'($past(coef_index_reg) + 1'b1))
        else $error("coefficient index did not advance by one");

    a_index_start: assert property (@(posedge clk) disable iff (!rst_n)
        !coef_valid_reg || last_reg |=> !coef_valid_reg || coef_index_reg == '0)
        else $error("new direction did not start at index zero");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid_reg && last_reg |-> coef_index_reg == last_k)
        else $error("final coefficient does not match band count");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid_reg && degenerate_reg |-> coef_value_reg == '0)
        else $error("degenerate result carries a nonzero value");
`endif

endmodule

// ===== sim/tb_spherical_harmonic_basis.sv =====
// Self-checking testbench for the spherical harmonic basis block.
`timescale 1ns / 1ps

// Scoreboard: predicts the coefficient stream of each direction and checks results.
class shb_scoreboard;
    typedef struct {
        logic [3:0]         index;
        logic signed [15:0] value;
        logic               degen;
        logic               last;
    } coef_t;

    coef_t       pending_coefs[$];
    logic [2:0]  bands;
    int          mismatch_count;

    function new();
        bands          = shb_pkg::BANDS_RESET;
        mismatch_count = 0;
    endfunction

    // Round half away from zero after dropping sh fraction bits.
    function longint shift_round(longint val, int sh);
        longint mag;
        mag = (val < 0) ? -val : val;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (val < 0) ? -mag : mag;
    endfunction

    // Unit component in Q15, clamped to the range -1..1.
    function longint to_unit(longint comp, longint rad);
        longint mag;
        longint q;
        mag = (comp < 0) ? -comp : comp;
        q = (mag * 32768 + rad / 2) / rad;
        if (q > 32768)
            q = 32768;
        return (comp < 0) ? -q : q;
    endfunction

    function longint norm_const(int k);
        case (k)
            0:       return 295798;
            1, 2, 3: return 512337;
            4, 5, 7: return 1145620;
            6:       return 330712;
            8:       return 572810;
            9, 15:   return 618706;
            10:      return 3031026;
            11, 13:  return 479247;
            12:      return 391304;
            default: return 1515513;
        endcase
    endfunction

    // Note an accepted direction and queue its expected coefficients.
    function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                 logic signed [15:0] dz, logic [15:0] rad);
        longint u, v, w, uu, vv, ww, t4, val, hi, lo;
        longint poly[16];
        int     nb;
        int     count;
        coef_t  c;
        nb = bands;
        if (nb < 2) nb = 2;
        if (nb > 4) nb = 4;
        count = nb * nb;
        if (rad != 0) begin
            u = to_unit(longint'(dx), longint'(rad));
            v = to_unit(longint'(dy), longint'(rad));
            w = to_unit(longint'(dz), longint'(rad));
            uu = u * u; vv = v * v; ww = w * w;
            t4 = 4 * ww - uu - vv;
            poly[0]  = 64'sd1 <<< 30;
            poly[1]  = v * 32768;
            poly[2]  = w * 32768;
            poly[3]  = u * 32768;
            poly[4]  = u * v;
            poly[5]  = v * w;
            poly[6]  = 2 * ww - uu - vv;
            poly[7]  = w * u;
            poly[8]  = uu - vv;
            poly[9]  = shift_round((3 * uu - vv) * v, 15);
            poly[10] = shift_round(u * v * w, 15);
            poly[11] = shift_round(v * t4, 15);
            poly[12] = shift_round(w * (2 * ww - 3 * uu - 3 * vv), 15);
            poly[13] = shift_round(u * t4, 15);
            poly[14] = shift_round((uu - vv) * w, 15);
            poly[15] = shift_round((uu - 3 * vv) * u, 15);
        end
        hi = 32767;
        lo = -32768;
        for (int k = 0; k < count; k++) begin
            val = 0;
            if (rad != 0) begin
                val = shift_round(norm_const(k) * poly[k], 35);
                if (val > hi) val = hi;
                if (val < lo) val = lo;
            end
            c.index = k[3:0];
            c.value = val[15:0];
            c.degen = (rad == 0);
            c.last  = (k == count - 1);
            pending_coefs.push_back(c);
        end
    endfunction

    // Compare one coefficient transfer with the oldest expectation.
    function void check_coef(logic [3:0] idx, logic signed [15:0] value,
                             logic degen, logic last);
        coef_t c;
        if (pending_coefs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected coefficient: index %0d value %0d", idx, value);
            return;
        end
        c = pending_coefs.pop_front();
        if (idx !== c.index || value !== c.value || degen !== c.degen || last !== c.last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch: expected idx %0d val %0d deg %0b last %0b, %s %0d %0d %0b %0b",
                         c.index, c.value, c.degen, c.last, "got", idx, value, degen, last);
        end
    endfunction
endclass

module tb_spherical_harmonic_basis;
    import shb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic [DW-1:0]        radius;
    logic                 coef_valid;
    logic [IDX_W-1:0]     coef_index;
    logic signed [DW-1:0] coef_value;
    logic                 degenerate;
    logic                 last;

    shb_scoreboard sb;
    int            idle_cycles = 0;
    bit            timed_out = 1'b0;

    spherical_harmonic_basis u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .radius     (radius),
        .coef_valid (coef_valid),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .degenerate (degenerate),
        .last       (last)
    );

    // 12 ns clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result monitor and watchdog on idle cycles.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (coef_valid)
                sb.check_coef(coef_index, coef_value, degenerate, last);
            if (coef_valid || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("spherical_harmonic_basis verification failed");
            $finish;
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic write_band_count(input logic [2:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BAND_COUNT, 2'b00};
        pwdata  <= {29'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.bands = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One direction transfer, after a random gap; start stays high for back-to-back items.
    task automatic send_direction(input logic signed [15:0] dx, input logic signed [15:0] dy,
                                  input logic signed [15:0] dz, input logic [15:0] rad);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        dir_x  <= dx;
        dir_y  <= dy;
        dir_z  <= dz;
        radius <= rad;
        start  <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_direction(dx, dy, dz, rad);
    endtask

    // Drop start, wait for every queued coefficient, then for the pipeline to drain.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_coefs.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random direction: mostly normalized-ish vectors, sometimes raw noise.
    task automatic send_random();
        logic signed [15:0] dx, dy, dz;
        logic [15:0]        rad;
        int                 m;
        dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom);
        case ($urandom_range(0, 9))
            0:       rad = 16'd0;
            1, 2:    rad = 16'($urandom);
            3:       rad = 16'($urandom_range(1, 16));
            default:
            begin
                m = (dx < 0) ? -int'(dx) : int'(dx);
                if (((dy < 0) ? -int'(dy) : int'(dy)) > m) m = (dy < 0) ? -int'(dy) : int'(dy);
                if (((dz < 0) ? -int'(dz) : int'(dz)) > m) m = (dz < 0) ? -int'(dz) : int'(dz);
                m = m + int'($urandom_range(0, 40000));
                rad = (m > 65535) ? 16'hffff : m[15:0];
                if (rad == 0) rad = 1;
            end
        endcase
        send_direction(dx, dy, dz, rad);
    endtask

    initial
    begin
        logic [2:0] band_settings[6];
        sb      = new();
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        dir_x   = '0;
        dir_y   = '0;
        dir_z   = '0;
        radius  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed directions at the reset band count.
        send_direction(16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_direction(16'sd32767, 16'sd0, 16'sd0, 16'd32767);
        send_direction(16'sd0, -16'sd32768, 16'sd0, 16'd32768);
        send_direction(16'sd0, 16'sd0, 16'sd32767, 16'd32767);
        send_direction(-16'sd32768, -16'sd32768, -16'sd32768, 16'd1);
        send_direction(16'sd32767, 16'sd32767, 16'sd32767, 16'd65535);
        send_direction(16'sd18919, -16'sd18919, 16'sd18919, 16'd32768);
        send_direction(-16'sd1, 16'sd1, -16'sd1, 16'd2);
        send_direction(16'sd23170, 16'sd23170, 16'sd0, 16'd32768);
        send_direction(16'sd100, 16'sd200, -16'sd300, 16'd0);
        send_direction(-16'sd32768, 16'sd32767, -16'sd32768, 16'd65535);
        drain();

        // Register sweep: extremes, clamped values and the ordinary settings.
        band_settings = '{3'd0, 3'd7, 3'd2, 3'd1, 3'd3, 3'd4};
        foreach (band_settings[s]) begin
            write_band_count(band_settings[s]);
            send_direction(16'sd0, 16'sd0, 16'sd0, 16'd0);
            send_direction(16'sd12000, -16'sd9000, 16'sd30000, 16'd32768);
            for (int n = 0; n < 50; n++)
                send_random();
            drain();
        end

        if (sb.mismatch_count == 0 && sb.pending_coefs.size() == 0)
            $display("spherical_harmonic_basis verification clean");
        else
            $display("spherical_harmonic_basis verification failed");
        $finish;
    end
endmodule
